// ===== src/tpac_pkg.sv =====
// Shared types, codes, reset values and the colour word unpacker
// for the TGA pixel to ARGB converter. No dependencies.
package tpac_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_KIND  = 3'd0,
    REG_PIXEL_BITS  = 3'd1,
    REG_ENTRY_BITS  = 3'd2,
    REG_ALPHA_BITS  = 3'd3,
    REG_FIRST_INDEX = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CMAP = 2'd0,
    KIND_TRUE = 2'd1,
    KIND_GRAY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  localparam logic [1:0]  IMAGE_KIND_RST  = 2'd1;
  localparam logic [5:0]  PIXEL_BITS_RST  = 6'd24;
  localparam logic [5:0]  ENTRY_BITS_RST  = 6'd24;
  localparam logic [3:0]  ALPHA_BITS_RST  = 4'd0;
  localparam logic [15:0] FIRST_INDEX_RST = 16'd0;

  typedef struct packed {
    logic [1:0]  image_kind;
    logic [5:0]  pixel_bits;
    logic [5:0]  entry_bits;
    logic [3:0]  alpha_bits;
    logic [15:0] first_index;
  } cfg_t;

  // lookup stage -> convert stage
  typedef struct packed {
    logic        valid;
    logic        range_err;
    logic [31:0] pword;
    logic [31:0] entry;
  } s1_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] argb;
  } unpack_t;

  // d / 3 for d < 64
  function automatic logic [4:0] div3(input logic [5:0] d);
    logic [11:0] p;
    p = {6'b000000, d} * 12'd43;
    return p[11:7];
  endfunction

  // 255 / (2^c - 1)
  function automatic logic [7:0] ratio_of(input logic [3:0] c);
    logic [7:0] r;
    case (c)
      4'd1:    r = 8'd255;
      4'd2:    r = 8'd85;
      4'd3:    r = 8'd36;
      4'd4:    r = 8'd17;
      4'd5:    r = 8'd8;
      4'd6:    r = 8'd4;
      4'd7:    r = 8'd2;
      4'd8:    r = 8'd1;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic unpack_t unpack_word(input logic [31:0] raw, input logic [5:0] w,
                                          input logic [3:0] a);
    unpack_t     r;
    logic [5:0]  d;
    logic [4:0]  c;
    logic [3:0]  cn;
    logic [31:0] data;
    logic [31:0] sh;
    logic [4:0]  shamt;
    logic [7:0]  maxv;
    logic [7:0]  ratio;
    logic [7:0]  comp;
    logic [15:0] prod;
    logic [23:0] res;
    logic [7:0]  amask;
    logic [7:0]  araw;
    logic [7:0]  alpha;
    d = w - {2'b00, a};
    c = div3(d);
    r.ok = (w >= 6'd1) && (w <= 6'd32) && (a <= 4'd8) && ({2'b00, a} <= w) &&
           (c >= 5'd1) && (c <= 5'd8);
    cn = c[3:0];
    if (w >= 6'd32) begin
      data = raw;
    end else begin
      data = raw & ((32'd1 << w) - 32'd1);
    end
    maxv = 8'((9'd1 << cn) - 9'd1);
    ratio = ratio_of(cn);
    res = '0;
    for (int k = 0; k < 3; k++) begin
      shamt = 5'(cn * k);
      sh = data >> shamt;
      comp = sh[7:0] & maxv;
      prod = {8'h00, comp} * {8'h00, ratio};
      res[8*k +: 8] = prod[7:0];
    end
    // alpha sits at the top of the byte, not replicated
    amask = 8'((9'd1 << a) - 9'd1);
    sh = data >> d;
    araw = sh[7:0] & amask;
    if (a == 4'd0) begin
      alpha = 8'hFF;
    end else begin
      alpha = araw << (4'd8 - a);
    end
    r.argb = r.ok ? {alpha, res} : 32'd0;
    return r;
  endfunction

endpackage

// ===== src/tpac_if.sv =====
// Valid/ready channel interfaces for pixel items and ARGB results.
// Depends on nothing.
interface tpac_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  entry_slot;
  logic [31:0] entry_word;
  logic [31:0] pixel_word;
  modport source (output valid, cmd, entry_slot, entry_word, pixel_word, input ready);
  modport sink (input valid, cmd, entry_slot, entry_word, pixel_word, output ready);
endinterface

interface tpac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb;
  logic [1:0]  status;
  modport source (output valid, argb, status, input ready);
  modport sink (input valid, argb, status, output ready);
endinterface

// ===== src/tga_pixel_to_argb_converter_unit.sv =====
// Top level of the TGA pixel to ARGB8888 converter.
// Depends on tpac_pkg, tpac_if, tpac_cfg_regs, tpac_lookup, tpac_convert.
//
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     cmd, entry_slot, entry_word, pixel_word
//  out_ch   out  valid/ready     argb, status
//  cfg_*    in   cfg_we          cfg_index, cfg_wdata
//
// One item per clock sustained while the output is not stalled; a pixel result
// passes the palette read register, then the result register.
// Palette writes produce no result and finish in the cycle they are accepted.
// Reset clears the pipeline valids and the config registers; palette is not cleared.
// A stalled output holds its result; the input keeps taking items while the
// lookup stage is free.
module tga_pixel_to_argb_converter_unit
  import tpac_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpac_in_if.sink               in_ch,
  tpac_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  s1_t  s1;
  logic s1_ready;

  tpac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpac_lookup #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  tpac_convert u_convert (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1       (s1),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/tpac_cfg_regs.sv =====
// Configuration register file, written through a plain write port.
// Depends on tpac_pkg.
module tpac_cfg_regs
  import tpac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_KIND:  cfg_nxt.image_kind  = cfg_wdata[1:0];
        REG_PIXEL_BITS:  cfg_nxt.pixel_bits  = cfg_wdata[5:0];
        REG_ENTRY_BITS:  cfg_nxt.entry_bits  = cfg_wdata[5:0];
        REG_ALPHA_BITS:  cfg_nxt.alpha_bits  = cfg_wdata[3:0];
        REG_FIRST_INDEX: cfg_nxt.first_index = cfg_wdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_kind  <= IMAGE_KIND_RST;
      cfg_r.pixel_bits  <= PIXEL_BITS_RST;
      cfg_r.entry_bits  <= ENTRY_BITS_RST;
      cfg_r.alpha_bits  <= ALPHA_BITS_RST;
      cfg_r.first_index <= FIRST_INDEX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tpac_lookup.sv =====
// Input stage: palette memory, index range check and the stage register.
// Depends on tpac_pkg and tpac_in_if.
module tpac_lookup
  import tpac_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tpac_in_if.sink   in_ch,
  input  cfg_t      cfg,
  input  logic      s1_ready,
  output s1_t       s1
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [31:0] mem [PALETTE_ENTRIES];

  logic          s1_valid_r, s1_valid_nxt;
  logic          range_err_r;
  logic [31:0]   pword_r;
  logic [31:0]   entry_r;
  logic          in_ready;
  logic          accept;
  logic [31:0]   slot_ext;
  logic          slot_ok;
  logic [31:0]   idx;
  logic [31:0]   first_ext;
  logic [31:0]   off;
  logic          range_err;

  assign in_ready = !s1_valid_r || s1_ready;
  assign in_ch.ready = in_ready;
  assign accept = in_ch.valid && in_ready;

  assign slot_ext = {24'h000000, in_ch.entry_slot};
  assign slot_ok = slot_ext < 32'(PALETTE_ENTRIES);

  always_comb begin
    case (cfg.pixel_bits)
      6'd8:    idx = {24'h000000, in_ch.pixel_word[7:0]};
      6'd16:   idx = {16'h0000, in_ch.pixel_word[15:0]};
      default: idx = in_ch.pixel_word;
    endcase
  end

  assign first_ext = {16'h0000, cfg.first_index};
  assign off = idx - first_ext;
  assign range_err = (idx < first_ext) || (off >= 32'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (accept && (cmd_t'(in_ch.cmd) == CMD_WRITE) && slot_ok) begin
      mem[slot_ext[AW-1:0]] <= in_ch.entry_word;
    end
    if (in_ready) begin
      entry_r <= mem[off[AW-1:0]];
    end
  end

  assign s1_valid_nxt = in_ready ? (accept && (cmd_t'(in_ch.cmd) == CMD_PIXEL)) : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      range_err_r <= range_err;
      pword_r     <= in_ch.pixel_word;
    end
  end

  assign s1.valid     = s1_valid_r;
  assign s1.range_err = range_err_r;
  assign s1.pword     = pword_r;
  assign s1.entry     = entry_r;

endmodule

// ===== src/tpac_convert.sv =====
// Output stage: format checks, colour unpacking and the result register.
// Depends on tpac_pkg and tpac_out_if.
module tpac_convert
  import tpac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  s1_t         s1,
  output logic        s1_ready,
  tpac_out_if.source  out_ch
);

  logic        out_valid_r;
  logic [31:0] argb_r, argb_nxt;
  status_t     status_r, status_nxt;
  unpack_t     ent;
  unpack_t     tc;
  logic        pix_ok;
  logic [2:0]  nbytes;
  logic [7:0]  gray;
  logic [7:0]  galpha;

  assign s1_ready = !out_valid_r || out_ch.ready;

  assign ent = unpack_word(s1.entry, cfg.entry_bits, cfg.alpha_bits);
  assign tc  = unpack_word(s1.pword, cfg.pixel_bits, cfg.alpha_bits);
  assign pix_ok = (cfg.pixel_bits == 6'd8) || (cfg.pixel_bits == 6'd16) ||
                  (cfg.pixel_bits == 6'd32);
  assign nbytes = cfg.pixel_bits[5:3];
  assign gray = s1.pword[7:0];
  assign galpha = (nbytes == 3'd2) ? s1.pword[15:8] : 8'hFF;

  always_comb begin
    argb_nxt = 32'd0;
    status_nxt = ST_OK;
    case (kind_t'(cfg.image_kind))
      KIND_CMAP: begin
        // format errors win over the range error
        if (!pix_ok || !ent.ok) begin
          status_nxt = ST_UNSUP;
        end else if (s1.range_err) begin
          status_nxt = ST_RANGE;
        end else begin
          argb_nxt = ent.argb;
        end
      end
      KIND_TRUE: begin
        if (!tc.ok) begin
          status_nxt = ST_UNSUP;
        end else begin
          argb_nxt = tc.argb;
        end
      end
      KIND_GRAY: begin
        if (nbytes != 3'd1 && nbytes != 3'd2) begin
          status_nxt = ST_UNSUP;
        end else begin
          argb_nxt = {galpha, gray, gray, gray};
        end
      end
      default: status_nxt = ST_UNSUP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1.valid) begin
      argb_r   <= argb_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.argb   = argb_r;
  assign out_ch.status = status_r;

endmodule

// ===== src/tpac_checker.sv =====
// Port-level checks for the converter, bound to the top level.
// Depends on tpac_pkg.
module tpac_checker
  import tpac_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_argb,
  input logic [1:0]  out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_argb) && $stable(out_status))
    else $error("result changed while stalled");

  // any error status carries a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_argb == 32'd0)
    else $error("error result with nonzero argb");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_RANGE) ||
                  (out_status == ST_UNSUP))
    else $error("undefined status code");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tga_pixel_to_argb_converter_unit tpac_checker u_tpac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_argb   (out_ch.argb),
  .out_status (out_ch.status)
);
